/* rtl/core/btk_pkg.sv */
`default_nettype none
package btk_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 16;
  localparam int SCORE_W     = 14;
  localparam int SUM_W       = 18;
  localparam int CAP_W       = 5;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [SCORE_W-1:0] SCORE_MAX   = SCORE_W'(10000);
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
  localparam logic [CNT_W-1:0]   CNT_ENTRIES = CNT_W'(MAX_ENTRIES);

  localparam logic KIND_APPLY = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // register index, taken from paddr word address
  localparam logic REG_CAPACITY = 1'b0;

  // data handed from one cell to the next
  typedef struct packed {
    logic               ge;
    logic               tie;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    logic               wr_en;
    logic               replace;
    logic [ID_W-1:0]    new_id;
    logic [SCORE_W-1:0] new_score;
    logic [SCORE_W-1:0] last_score;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/bounded_top_k_sorted_list_unit.sv */
`default_nettype none
// Bounded top-k list: keeps up to capacity (id, score) entries sorted by
// score, highest first, in a row of 16 cells; capacity 0 acts as 1 and above
// 16 as 16. start is taken whenever busy is low, and busy never rises, so an
// item may be issued every clock. The result appears on the result ports,
// marked by done, in the cycle after start and for that cycle only; the
// receiver must take it then. Insertion compares the new score in all cells
// at once and cells below the new entry load their left neighbor, so the
// list shifts in the same cycle. Scores above 10000 are saturated. capacity
// is at APB address 0 and should only be written while no item is in flight.
module bounded_top_k_sorted_list_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                kind,
  input  wire  [btk_pkg::ID_W-1:0]           applicant_id,
  input  wire  [btk_pkg::SCORE_W-1:0]        applicant_score,
  input  wire  [btk_pkg::IDX_W-1:0]          read_index,
  output logic                               done,
  output logic                               accepted,
  output logic [btk_pkg::CNT_W-1:0]          stored_count,
  output logic [btk_pkg::SUM_W-1:0]          score_sum,
  output logic                               entry_valid,
  output logic [btk_pkg::ID_W-1:0]           entry_id,
  output logic [btk_pkg::SCORE_W-1:0]        entry_score,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [btk_pkg::ADDR_W-1:0]         paddr,
  input  wire  [btk_pkg::DATA_W-1:0]         pwdata,
  output logic [btk_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int N = btk_pkg::MAX_ENTRIES;

  logic [btk_pkg::CAP_W-1:0]   capacity;
  logic [btk_pkg::CNT_W-1:0]   count;
  logic [btk_pkg::CNT_W-1:0]   count_next;
  logic [btk_pkg::SUM_W-1:0]   sum;
  logic [btk_pkg::SUM_W-1:0]   sum_next;
  logic [btk_pkg::CNT_W-1:0]   eff_cap;
  logic [btk_pkg::SCORE_W-1:0] sc;
  logic [btk_pkg::SCORE_W-1:0] last_score;
  logic [btk_pkg::ID_W-1:0]    rd_id;
  logic [btk_pkg::SCORE_W-1:0] rd_score;
  logic                        rd_valid;
  logic                        full;
  logic                        do_ins;
  logic                        do_rep;
  logic                        cfg_wr;
  logic [N-1:0]                occ;
  btk_pkg::cell_ctl_t          ctl;
  btk_pkg::link_t              chain [0:N];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // ---------------- configuration ----------------
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == btk_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= btk_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[btk_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == btk_pkg::REG_CAPACITY) begin
      prdata = btk_pkg::DATA_W'(capacity);
    end
  end

  // ---------------- decision ----------------
  always_comb begin
    if (capacity == '0) begin
      eff_cap = btk_pkg::CNT_W'(1);
    end else if (btk_pkg::CNT_W'(capacity) > btk_pkg::CNT_ENTRIES) begin
      eff_cap = btk_pkg::CNT_ENTRIES;
    end else begin
      eff_cap = btk_pkg::CNT_W'(capacity);
    end
  end

  assign sc = (applicant_score > btk_pkg::SCORE_MAX) ? btk_pkg::SCORE_MAX : applicant_score;

  // one-hot pick of the last held entry and of the read position
  always_comb begin
    last_score = '0;
    rd_id      = '0;
    rd_score   = '0;
    for (int i = 0; i < N; i++) begin
      occ[i] = btk_pkg::CNT_W'(i) < count;
      if (btk_pkg::CNT_W'(i + 1) == count) begin
        last_score = last_score | chain[i+1].score;
      end
      if (btk_pkg::IDX_W'(i) == read_index) begin
        rd_id    = rd_id | chain[i+1].id;
        rd_score = rd_score | chain[i+1].score;
      end
    end
  end

  assign rd_valid = btk_pkg::CNT_W'(read_index) < count;

  assign full   = count >= eff_cap;
  assign do_ins = start && (kind == btk_pkg::KIND_APPLY) && !full;
  assign do_rep = start && (kind == btk_pkg::KIND_APPLY) && full &&
                  (count != '0) && (last_score < sc);

  assign ctl.wr_en      = do_ins || do_rep;
  assign ctl.replace    = do_rep;
  assign ctl.new_id     = applicant_id;
  assign ctl.new_score  = sc;
  assign ctl.last_score = last_score;

  always_comb begin
    count_next = count;
    sum_next   = sum;
    if (do_ins) begin
      count_next = count + btk_pkg::CNT_W'(1);
      sum_next   = sum + btk_pkg::SUM_W'(sc);
    end else if (do_rep) begin
      sum_next   = sum + btk_pkg::SUM_W'(sc) - btk_pkg::SUM_W'(last_score);
    end
  end

  // ---------------- cell row ----------------
  assign chain[0] = '{ge: 1'b1, tie: 1'b0, id: '0, score: '0};

  for (genvar g = 0; g < N; g++) begin : g_cell
    btk_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (occ[g]),
      .left     (chain[g]),
      .right    (chain[g+1])
    );
  end

  // ---------------- state and result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
        sum   <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      accepted     <= do_ins || do_rep;
      stored_count <= count_next;
      score_sum    <= sum_next;
      if (kind == btk_pkg::KIND_READ && rd_valid) begin
        entry_valid <= 1'b1;
        entry_id    <= rd_id;
        entry_score <= rd_score;
      end else begin
        entry_valid <= 1'b0;
        entry_id    <= '0;
        entry_score <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= btk_pkg::CNT_ENTRIES)
    else $error("held count above list size");

  a_one_per_item: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("item gave no result");

  a_read_apply_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(accepted && entry_valid))
    else $error("result both stored and read");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !start |=> count == $past(count))
    else $error("count moved without an item");
`endif

endmodule
`default_nettype wire

/* rtl/core/btk_cell.sv */
`default_nettype none
module btk_cell (
  input  wire                 clk,
  input  wire btk_pkg::cell_ctl_t ctl,
  input  wire                 occupied,
  input  wire btk_pkg::link_t left,
  output btk_pkg::link_t      right
);

  logic [btk_pkg::ID_W-1:0]    id;
  logic [btk_pkg::SCORE_W-1:0] score;
  logic                        ge;
  logic                        tie;
  logic                        hold;

  assign ge  = occupied && (score >= ctl.new_score);
  assign tie = occupied && (score == ctl.last_score);

  // on a replace, cells past the evicted entry keep their place
  assign hold = ge || (ctl.replace && left.tie);

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !hold) begin
      if (left.ge) begin
        id    <= ctl.new_id;
        score <= ctl.new_score;
      end else begin
        id    <= left.id;
        score <= left.score;
      end
    end
  end

  assign right.ge    = ge;
  assign right.tie   = tie;
  assign right.id    = id;
  assign right.score = score;

endmodule
`default_nettype wire

/* sim/bounded_top_k_sorted_list_unit_test.sv */
`default_nettype none
module bounded_top_k_sorted_list_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        accepted;
    logic [btk_pkg::CNT_W-1:0]   count;
    logic [btk_pkg::SUM_W-1:0]   sum;
    logic                        valid;
    logic [btk_pkg::ID_W-1:0]    id;
    logic [btk_pkg::SCORE_W-1:0] score;
  } list_result_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_op_t;

  typedef struct packed {
    row_op_t                     op;
    logic                        kind;
    logic [btk_pkg::ID_W-1:0]    id;
    logic [btk_pkg::SCORE_W-1:0] score;
    logic [btk_pkg::IDX_W-1:0]   idx;
    logic [btk_pkg::CAP_W-1:0]   cap;
    logic                        typed;
    list_result_t                want;
  } script_row_t;

  localparam int NUM_ROWS   = 23;
  localparam int NUM_PHASES = 13;
  localparam int PHASE_LEN  = 88;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         kind;
  logic [btk_pkg::ID_W-1:0]     applicant_id;
  logic [btk_pkg::SCORE_W-1:0]  applicant_score;
  logic [btk_pkg::IDX_W-1:0]    read_index;
  logic                         done;
  logic                         accepted;
  logic [btk_pkg::CNT_W-1:0]    stored_count;
  logic [btk_pkg::SUM_W-1:0]    score_sum;
  logic                         entry_valid;
  logic [btk_pkg::ID_W-1:0]     entry_id;
  logic [btk_pkg::SCORE_W-1:0]  entry_score;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [btk_pkg::ADDR_W-1:0]   paddr;
  logic [btk_pkg::DATA_W-1:0]   pwdata;
  logic [btk_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  bounded_top_k_sorted_list_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .applicant_id(applicant_id), .applicant_score(applicant_score),
    .read_index(read_index), .done(done), .accepted(accepted),
    .stored_count(stored_count), .score_sum(score_sum),
    .entry_valid(entry_valid), .entry_id(entry_id), .entry_score(entry_score),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the list
  logic [btk_pkg::ID_W-1:0]    list_ids    [btk_pkg::MAX_ENTRIES];
  logic [btk_pkg::SCORE_W-1:0] list_scores [btk_pkg::MAX_ENTRIES];
  logic [btk_pkg::CNT_W-1:0]   list_len;
  logic [btk_pkg::SUM_W-1:0]   list_total;
  logic [btk_pkg::CAP_W-1:0]   cap_setting;

  list_result_t pending_results [$];
  int           error_count;
  script_row_t  script [NUM_ROWS];
  logic [btk_pkg::CAP_W-1:0] phase_caps [NUM_PHASES];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // entry goes after every stored entry with an equal or higher score
  function automatic void insert_entry(input logic [btk_pkg::ID_W-1:0] aid,
                                       input logic [btk_pkg::SCORE_W-1:0] sc);
    int pos;
    pos = 0;
    while (pos < list_len && list_scores[pos] >= sc) pos++;
    for (int i = list_len; i > pos; i--) begin
      list_ids[i]    = list_ids[i-1];
      list_scores[i] = list_scores[i-1];
    end
    list_ids[pos]    = aid;
    list_scores[pos] = sc;
    list_len++;
    list_total = list_total + sc;
  endfunction

  function automatic list_result_t predict_list(
      input logic k,
      input logic [btk_pkg::ID_W-1:0] aid,
      input logic [btk_pkg::SCORE_W-1:0] asc,
      input logic [btk_pkg::IDX_W-1:0] ridx);
    list_result_t                r;
    logic [btk_pkg::SCORE_W-1:0] sc;
    int                          limit;
    int                          low;
    r = '0;
    sc = (asc > btk_pkg::SCORE_MAX) ? btk_pkg::SCORE_MAX : asc;
    limit = (cap_setting == 0) ? 1
          : (cap_setting > btk_pkg::MAX_ENTRIES) ? btk_pkg::MAX_ENTRIES
          : int'(cap_setting);
    if (k == btk_pkg::KIND_APPLY) begin
      if (list_len < limit) begin
        insert_entry(aid, sc);
        r.accepted = 1'b1;
      end else if (list_len > 0) begin
        low = 0;
        for (int i = 1; i < list_len; i++)
          if (list_scores[i] < list_scores[low]) low = i;
        if (list_scores[low] < sc) begin
          list_total = list_total - list_scores[low];
          for (int i = low; i + 1 < list_len; i++) begin
            list_ids[i]    = list_ids[i+1];
            list_scores[i] = list_scores[i+1];
          end
          list_len--;
          insert_entry(aid, sc);
          r.accepted = 1'b1;
        end
      end
    end else if (ridx < list_len) begin
      r.valid = 1'b1;
      r.id    = list_ids[ridx];
      r.score = list_scores[ridx];
    end
    r.count = list_len;
    r.sum   = list_total;
    return r;
  endfunction

  task automatic issue_item(input logic k, input logic [btk_pkg::ID_W-1:0] aid,
                            input logic [btk_pkg::SCORE_W-1:0] asc,
                            input logic [btk_pkg::IDX_W-1:0] ridx,
                            input logic typed, input list_result_t want);
    list_result_t pred;
    @(negedge clk);
    start           <= 1'b1;
    kind            <= k;
    applicant_id    <= aid;
    applicant_score <= asc;
    read_index      <= ridx;
    do @(posedge clk); while (busy);
    pred = predict_list(k, aid, asc, ridx);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // stop issuing and let every outstanding result come back
  task automatic settle_list();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [btk_pkg::CAP_W-1:0] value);
    logic [btk_pkg::DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[btk_pkg::CAP_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {btk_pkg::REG_CAPACITY, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_setting = value;
    // read back right away, psel stays high into the read setup
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== btk_pkg::DATA_W'(value))
      report_mismatch($sformatf("capacity read back %0d, wrote %0d", prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", accepted, want.accepted);
        check_field("stored_count", stored_count, want.count);
        check_field("score_sum", score_sum, want.sum);
        check_field("entry_valid", entry_valid, want.valid);
        check_field("entry_id", entry_id, want.id);
        check_field("entry_score", entry_score, want.score);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic                        k;
    logic [btk_pkg::ID_W-1:0]    aid;
    logic [btk_pkg::SCORE_W-1:0] asc;
    logic [btk_pkg::IDX_W-1:0]   ridx;
    logic                        gappy;
    rst             <= 1'b1;
    start           <= 1'b0;
    kind            <= btk_pkg::KIND_APPLY;
    applicant_id    <= '0;
    applicant_score <= '0;
    read_index      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    error_count = 0;
    list_len    = '0;
    list_total  = '0;
    cap_setting = btk_pkg::CAP_RESET;
    for (int i = 0; i < btk_pkg::MAX_ENTRIES; i++) begin
      list_ids[i]    = '0;
      list_scores[i] = '0;
    end

    // op, kind, id, score, index, capacity, typed, expected result
    script = '{
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd0,  5'd0,  1'b1,
        '{1'b0, 5'd0, 18'd0,     1'b0, 16'h0000, 14'd0}},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd15, 5'd0,  1'b1,
        '{1'b0, 5'd0, 18'd0,     1'b0, 16'h0000, 14'd0}},
      // score above range saturates
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'hFFFF, 14'd16383, 4'd15, 5'd0,  1'b1,
        '{1'b1, 5'd1, 18'd10000, 1'b0, 16'h0000, 14'd0}},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd0,  5'd0,  1'b1,
        '{1'b0, 5'd1, 18'd10000, 1'b1, 16'hFFFF, 14'd10000}},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0000, 14'd0,     4'd0,  5'd0,  1'b1,
        '{1'b1, 5'd2, 18'd10000, 1'b0, 16'h0000, 14'd0}},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0001, 14'd10000, 4'd0,  5'd0,  1'b1,
        '{1'b1, 5'd3, 18'd20000, 1'b0, 16'h0000, 14'd0}},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'hA5A5, 14'd1234,  4'd1,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0002, 14'd10001, 4'd9,  5'd0,  1'b0, '0},
      // zero capacity acts as one, list already holds four
      '{ROW_CAP,  btk_pkg::KIND_APPLY, 16'h0000, 14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0003, 14'd0,     4'd0,  5'd0,  1'b1,
        '{1'b0, 5'd4, 18'd30000, 1'b0, 16'h0000, 14'd0}},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0004, 14'd1,     4'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd3,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd4,  5'd0,  1'b1,
        '{1'b0, 5'd4, 18'd30001, 1'b0, 16'h0000, 14'd0}},
      // above the cell count acts as full size
      '{ROW_CAP,  btk_pkg::KIND_APPLY, 16'h0000, 14'd0,     4'd0,  5'd31, 1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0005, 14'd5000,  4'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0006, 14'd5000,  4'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd3,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd4,  5'd0,  1'b0, '0},
      // capacity below count: only the lowest entry can be replaced
      '{ROW_CAP,  btk_pkg::KIND_APPLY, 16'h0000, 14'd0,     4'd0,  5'd1,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0007, 14'd2,     4'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_APPLY, 16'h0008, 14'd16383, 4'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, btk_pkg::KIND_READ,  16'h0000, 14'd0,     4'd0,  5'd0,  1'b0, '0},
      '{ROW_CAP,  btk_pkg::KIND_APPLY, 16'h0000, 14'd0,     4'd0,  5'd16, 1'b0, '0}
    };
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd16, 5'd8,
                   5'd3, 5'd5, 5'd12, 5'd16};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      if (script[r].op == ROW_CAP) begin
        settle_list();
        write_capacity(script[r].cap);
      end else begin
        if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 14));
        issue_item(script[r].kind, script[r].id, script[r].score, script[r].idx,
                   script[r].typed, script[r].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_list();
      write_capacity(phase_caps[p]);
      gappy = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (gappy && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 14));
        k   = ($urandom_range(0, 9) < 7) ? btk_pkg::KIND_APPLY : btk_pkg::KIND_READ;
        aid = btk_pkg::ID_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
          0:       asc = '0;
          1:       asc = btk_pkg::SCORE_MAX;
          2:       asc = btk_pkg::SCORE_W'($urandom_range(10001, 16383));
          3, 4:    asc = btk_pkg::SCORE_W'(2500 * $urandom_range(0, 4));  // frequent ties
          default: asc = btk_pkg::SCORE_W'($urandom_range(0, 10000));
        endcase
        if ($urandom_range(0, 1) == 1 && list_len > 0)
          ridx = btk_pkg::IDX_W'($urandom_range(0, list_len - 1));
        else
          ridx = btk_pkg::IDX_W'($urandom_range(0, 15));
        issue_item(k, aid, asc, ridx, 1'b0, '0);
      end
    end

    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
